[hdl/prf_pkg.sv]
// Shared types, constants and command codes for the Pollard rho factoring block.
`default_nettype none
package prf_pkg;
	localparam int WIDTH = 64;
	localparam int CNT_W = $clog2(WIDTH + 1);

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_STEP  = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [1:0] OUT_FOUND     = 2'd0;
	localparam logic [1:0] OUT_GCD_N     = 2'd1;
	localparam logic [1:0] OUT_COLLIDE   = 2'd2;
	localparam logic [1:0] OUT_LIMIT     = 2'd3;

	// Datapath operations.
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1; // latch n, start reduction of start value when n is odd and not one
	localparam logic [2:0] OP_REDC   = 3'd2; // start reduction of c
	localparam logic [2:0] OP_STEPX  = 3'd3; // x = f(x)
	localparam logic [2:0] OP_STEPY  = 3'd4; // y = f(y)
	localparam logic [2:0] OP_GCD    = 3'd5; // start gcd(|x-y|, n)

	typedef struct packed {
		logic [2:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic done;      // multi-cycle operation finished
		logic x_eq_y;
		logic gcd_is_n;
		logic gcd_is_1;
		logic n_even;
		logic n_one;
	} dp_stat_t;
endpackage
`default_nettype wire

[hdl/prf_ctrl.sv]
// Controller state machine sequencing the rho walk.
`default_nettype none
module prf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [31:0]       limit,
	input  wire prf_pkg::dp_stat_t stat,
	output prf_pkg::dp_cmd_t       cmd,
	output logic                   busy,
	output logic                   done,
	output logic [1:0]             outcome,
	output logic                   factor_sel
);
	import prf_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_REDS  = 4'd2;
	localparam logic [3:0] S_REDC  = 4'd3;
	localparam logic [3:0] S_ROUND = 4'd4;
	localparam logic [3:0] S_STX   = 4'd5;
	localparam logic [3:0] S_STY1  = 4'd6;
	localparam logic [3:0] S_STY2  = 4'd7;
	localparam logic [3:0] S_GCD   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]  state_q, state_d;
	logic [31:0] round_q;
	logic [1:0]  outc_q, outc_d;
	logic        issued_q;

	always_comb begin
		state_d = state_q;
		outc_d  = outc_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.n_even) begin
					outc_d = OUT_FOUND;
					state_d = S_DONE;
				end else if (stat.n_one) begin
					outc_d = OUT_GCD_N;
					state_d = S_DONE;
				end else begin
					state_d = S_REDS;
				end
			end
			S_REDS: begin
				if (stat.done) begin
					cmd.op  = OP_REDC;
					state_d = S_REDC;
				end
			end
			S_REDC: if (stat.done) state_d = S_ROUND;
			S_ROUND: begin
				if (round_q >= limit) begin
					outc_d  = OUT_LIMIT;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_STEPX;
					state_d = S_STX;
				end
			end
			S_STX: begin
				if (stat.done) begin
					cmd.op  = OP_STEPY;
					state_d = S_STY1;
				end
			end
			S_STY1: begin
				if (stat.done) begin
					cmd.op  = OP_STEPY;
					state_d = S_STY2;
				end
			end
			S_STY2: begin
				if (stat.done) begin
					if (stat.x_eq_y) begin
						outc_d  = OUT_COLLIDE;
						state_d = S_DONE;
					end else begin
						cmd.op  = OP_GCD;
						state_d = S_GCD;
					end
				end
			end
			S_GCD: begin
				if (stat.done) begin
					if (stat.gcd_is_n) begin
						outc_d  = OUT_GCD_N;
						state_d = S_DONE;
					end else if (!stat.gcd_is_1) begin
						outc_d  = OUT_FOUND;
						state_d = S_DONE;
					end else begin
						state_d = S_ROUND;
					end
				end
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			round_q  <= '0;
			outc_q   <= OUT_FOUND;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			outc_q   <= outc_d;
			issued_q <= (cmd.op != OP_NONE);
			if (state_q == S_IDLE)
				round_q <= '0;
			else if (state_q == S_ROUND && round_q < limit)
				round_q <= round_q + 32'd1;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_DONE);
	assign outcome    = outc_q;
	// Even n reports the constant two rather than the gcd register.
	assign factor_sel = stat.n_even;

	ap_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STX) |-> (round_q <= limit))
		else $error("round count passed the limit");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than a cycle");
	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (state_q == S_IDLE))
		else $error("load issued while busy");
	ap_no_issue_twice: assert property (@(posedge clk) disable iff (!arst_n)
		issued_q && (state_q == S_STY1 || state_q == S_STY2) |-> (cmd.op == OP_NONE))
		else $error("step issued back to back");
endmodule
`default_nettype wire

[hdl/prf_dpath.sv]
// Datapath: bit-serial modular squaring, serial reduction and binary gcd.
`default_nettype none
module prf_dpath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire prf_pkg::dp_cmd_t           cmd,
	input  wire logic [prf_pkg::WIDTH-1:0]  n_in,
	input  wire logic [63:0]                start_value,
	input  wire logic [63:0]                step_constant,
	output prf_pkg::dp_stat_t               stat,
	output logic [prf_pkg::WIDTH-1:0]       gcd_value
);
	import prf_pkg::*;

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_RED  = 2'd1;
	localparam logic [1:0] U_MUL  = 2'd2;
	localparam logic [1:0] U_GCD  = 2'd3;

	localparam int SW = 6; // shift count of the gcd, enough for WIDTH up to 64

	logic [1:0]       unit_q;
	logic             tgt_c_q, tgt_y_q;
	logic [WIDTH-1:0] n_q, x_q, y_q, c_q;
	logic [WIDTH-1:0] acc_q, opb_q, opa_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      red_src_q;
	logic [6:0]       red_cnt_q;
	logic [WIDTH:0]   racc_q;
	logic [WIDTH-1:0] ga_q, gb_q;
	logic [SW:0]      gsh_q;
	logic             done_q;

	// Double-and-add step: r = 2r (+a) mod n, with one spare bit for the carry.
	logic [WIDTH:0] dbl, dbl_r, add1, add_r;
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		add1  = dbl_r + {1'b0, opa_q};
		add_r = (add1 >= {1'b0, n_q}) ? add1 - {1'b0, n_q} : add1;
	end
	logic [WIDTH-1:0] mul_next;
	assign mul_next = opb_q[WIDTH-1] ? add_r[WIDTH-1:0] : dbl_r[WIDTH-1:0];

	// Final add of c after the square.
	logic [WIDTH:0] fadd;
	logic [WIDTH-1:0] f_val;
	assign fadd  = {1'b0, acc_q} + {1'b0, c_q};
	assign f_val = (fadd >= {1'b0, n_q}) ? fadd[WIDTH-1:0] - n_q : fadd[WIDTH-1:0];

	// Serial reduction of a 64-bit word modulo n, one source bit a cycle.
	logic [WIDTH:0] rsh, rsh_r;
	always_comb begin
		rsh   = {racc_q[WIDTH-1:0], red_src_q[63]};
		rsh_r = (rsh >= {1'b0, n_q}) ? rsh - {1'b0, n_q} : rsh;
	end

	logic [WIDTH-1:0] diff;
	assign diff = (x_q > y_q) ? x_q - y_q : y_q - x_q;

	// Binary gcd subtract step on pairs that are both odd.
	logic [WIDTH-1:0] g_small, g_big;
	assign g_small = (ga_q < gb_q) ? ga_q : gb_q;
	assign g_big   = (ga_q < gb_q) ? gb_q : ga_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (unit_q)
				U_IDLE: begin
					case (cmd.op)
						OP_LOAD: begin
							n_q       <= n_in;
							red_src_q <= start_value;
							red_cnt_q <= 7'd64;
							racc_q    <= '0;
							tgt_c_q   <= 1'b0;
							// Even n and n equal to one are settled without a walk.
							if (n_in[0] && n_in != WIDTH'(1))
								unit_q <= U_RED;
						end
						OP_REDC: begin
							red_src_q <= step_constant;
							red_cnt_q <= 7'd64;
							racc_q    <= '0;
							tgt_c_q   <= 1'b1;
							unit_q    <= U_RED;
						end
						OP_STEPX, OP_STEPY: begin
							tgt_y_q <= (cmd.op == OP_STEPY);
							opa_q   <= (cmd.op == OP_STEPY) ? y_q : x_q;
							opb_q   <= (cmd.op == OP_STEPY) ? y_q : x_q;
							acc_q   <= '0;
							cnt_q   <= CNT_W'(WIDTH);
							unit_q  <= U_MUL;
						end
						OP_GCD: begin
							ga_q   <= diff;
							gb_q   <= n_q;
							gsh_q  <= '0;
							unit_q <= U_GCD;
						end
						default: ;
					endcase
				end
				U_RED: begin
					if (red_cnt_q == 7'd0) begin
						if (tgt_c_q) c_q <= racc_q[WIDTH-1:0];
						else begin
							x_q <= racc_q[WIDTH-1:0];
							y_q <= racc_q[WIDTH-1:0];
						end
						done_q <= 1'b1;
						unit_q <= U_IDLE;
					end else begin
						racc_q    <= rsh_r;
						red_src_q <= {red_src_q[62:0], 1'b0};
						red_cnt_q <= red_cnt_q - 7'd1;
					end
				end
				U_MUL: begin
					if (cnt_q == '0) begin
						if (tgt_y_q) y_q <= f_val;
						else x_q <= f_val;
						done_q <= 1'b1;
						unit_q <= U_IDLE;
					end else begin
						acc_q <= mul_next;
						opb_q <= {opb_q[WIDTH-2:0], 1'b0};
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				U_GCD: begin
					// Stein: strip common twos, then subtract down to zero.
					if (ga_q == '0 || gb_q == '0) begin
						gcd_value <= (ga_q | gb_q) << gsh_q;
						done_q    <= 1'b1;
						unit_q    <= U_IDLE;
					end else if (!ga_q[0] && !gb_q[0]) begin
						ga_q  <= ga_q >> 1;
						gb_q  <= gb_q >> 1;
						gsh_q <= gsh_q + (SW+1)'(1);
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else begin
						ga_q <= g_small;
						gb_q <= g_big - g_small;
					end
				end
				default: unit_q <= U_IDLE;
			endcase
		end
	end

	assign stat = '{
		done:     done_q,
		x_eq_y:   (x_q == y_q),
		gcd_is_n: (gcd_value == n_q),
		gcd_is_1: (gcd_value == WIDTH'(1)),
		n_even:   !n_q[0],
		n_one:    (n_q == WIDTH'(1))
	};

	ap_mul_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_q == U_MUL && cnt_q != '0) |=> (acc_q < n_q))
		else $error("modular accumulator left its range");
	ap_done_from_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(unit_q) != U_IDLE)
		else $error("done without a running unit");
	ap_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != OP_NONE) |-> (unit_q == U_IDLE))
		else $error("command while a unit runs");
endmodule
`default_nettype wire

[hdl/pollard_rho_factor.sv]
// Top level of the Pollard rho factoring block: registers, controller and datapath.
`default_nettype none
// One word n is taken when start is high and busy low; busy stays high until the
// result appears for a single cycle with done. Even n and n equal to one give their
// result from the check state, without a walk. Otherwise the start value and c are
// first reduced modulo n, and each round then passes the round state, three
// bit-serial modular squarings and a binary gcd, the number of rounds being set by
// the walk and capped by the iteration limit. The result cannot be held off and
// must be taken in the cycle that done is high.
module pollard_rho_factor (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [prf_pkg::WIDTH-1:0] number_to_factor,
	output logic                           done,
	output logic [63:0]                    found_factor,
	output logic [1:0]                     outcome,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [63:0]               cfg_data
);
	import prf_pkg::*;

	logic [63:0] start_q, step_q;
	logic [31:0] limit_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [WIDTH-1:0] gcd_value;
	logic        factor_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 64'd865;
			step_q  <= 64'd1;
			limit_q <= 32'd1048576;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START: start_q <= cfg_data;
				REG_STEP:  step_q  <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	prf_ctrl u_ctrl (
		.clk, .arst_n, .start, .limit(limit_q), .stat, .cmd,
		.busy, .done, .outcome, .factor_sel
	);

	prf_dpath u_dpath (
		.clk, .arst_n, .cmd, .n_in(number_to_factor),
		.start_value(start_q), .step_constant(step_q), .stat, .gcd_value
	);

	always_comb begin
		if (factor_sel)
			found_factor = 64'd2;
		else if (outcome == OUT_FOUND)
			found_factor = 64'(gcd_value);
		else
			found_factor = '0;
	end
endmodule
`default_nettype wire

[tb/sv/pollard_rho_factor_tb.sv]
// Self-checking testbench for the Pollard rho factoring block with a scoreboard class.
`default_nettype none
module pollard_rho_factor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import prf_pkg::*;

	localparam int WDOG_LIMIT = 400000;

	class factor_scoreboard;
		logic [63:0] start_val;
		logic [63:0] step_c;
		logic [31:0] round_limit;
		logic [63:0] factor_q[$];
		logic [1:0]  outcome_q[$];
		int          errors;

		function new();
			start_val   = 64'd865;
			step_c      = 64'd1;
			round_limit = 32'd1048576;
			errors      = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] val);
			case (idx)
				REG_START: start_val = val;
				REG_STEP:  step_c = val;
				REG_LIMIT: round_limit = val[31:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] rho_map(logic [63:0] v, logic [63:0] c, logic [63:0] m);
			logic [127:0] sq;
			logic [64:0]  s;
			sq = ({64'd0, v} * {64'd0, v}) % {64'd0, m};
			s = {1'b0, sq[63:0]} + {1'b0, c};
			if (s >= {1'b0, m})
				s = s - {1'b0, m};
			return s[63:0];
		endfunction

		function logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
			logic [63:0] t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		// Works out the expected factor and outcome for one accepted word.
		function void note_word(logic [63:0] n);
			logic [63:0] x, y, c, d, diff, fac;
			logic [1:0]  oc;
			logic [31:0] r;
			fac = 0;
			oc = OUT_LIMIT;
			if (!n[0]) begin
				fac = 64'd2;
				oc = OUT_FOUND;
			end else if (n == 64'd1) begin
				oc = OUT_GCD_N;
			end else begin
				x = start_val % n;
				y = x;
				c = step_c % n;
				for (r = 0; r < round_limit; r++) begin
					x = rho_map(x, c, n);
					y = rho_map(rho_map(y, c, n), c, n);
					if (x == y) begin
						oc = OUT_COLLIDE;
						break;
					end
					diff = (x > y) ? x - y : y - x;
					d = gcd64(diff, n);
					if (d == n) begin
						oc = OUT_GCD_N;
						break;
					end
					if (d != 1) begin
						fac = d;
						oc = OUT_FOUND;
						break;
					end
				end
			end
			factor_q.push_back(fac);
			outcome_q.push_back(oc);
		endfunction

		function void check_word(logic [63:0] ff, logic [1:0] oc);
			logic [63:0] e_ff;
			logic [1:0]  e_oc;
			if (factor_q.size() == 0) begin
				$display("%0t: unexpected result factor=%h outcome=%0d", $time, ff, oc);
				errors++;
				return;
			end
			e_ff = factor_q.pop_front();
			e_oc = outcome_q.pop_front();
			if (ff !== e_ff) begin
				$display("%0t: found_factor expected %h actual %h", $time, e_ff, ff);
				errors++;
			end
			if (oc !== e_oc) begin
				$display("%0t: outcome expected %0d actual %0d", $time, e_oc, oc);
				errors++;
			end
		endfunction

		function int pending();
			return factor_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] number_to_factor;
	logic        done;
	logic [63:0] found_factor;
	logic [1:0]  outcome;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	factor_scoreboard sb;
	int idle_cycles;

	pollard_rho_factor u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.number_to_factor(number_to_factor), .done(done),
		.found_factor(found_factor), .outcome(outcome),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_word(found_factor, outcome);
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
	endtask

	task automatic set_regs(logic [63:0] sv, logic [63:0] cv, logic [31:0] lv);
		write_reg(REG_START, sv);
		write_reg(REG_STEP, cv);
		write_reg(REG_LIMIT, {$urandom, lv});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends each word with a random gap; start stays high across back-to-back words.
	task automatic send_words(logic [63:0] words[$]);
		int gap;
		foreach (words[i]) begin
			gap = $urandom_range(0, 19);
			if (gap > 0) begin
				@(posedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end
			@(posedge clk);
			start <= 1'b1;
			number_to_factor <= words[i];
			do @(posedge clk); while (busy);
			sb.note_word(words[i]);
			if (i == words.size() - 1)
				start <= 1'b0;
			else
				start <= start;
		end
	endtask

	task automatic drain();
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// An odd word with a small prime factor, so the walk ends within a few rounds.
	function automatic logic [63:0] small_factor_word();
		int primes[5] = '{3, 5, 7, 11, 13};
		logic [63:0] p, m;
		p = primes[$urandom_range(0, 4)];
		m = rand64() / p;
		if (m == 0)
			m = 1;
		if (!m[0])
			m = m - 1;
		return m * p;
	endfunction

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 9))
			0: return {rand64()} & ~64'd1;
			1: return {32'd0, 16'd0, 16'($urandom)} | 64'd1;
			2, 3, 4: return rand64() | 64'd1;
			default: return small_factor_word();
		endcase
	endfunction

	initial begin
		logic [63:0] words[$];
		sb = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		number_to_factor = 64'd0;
		cfg_we = 1'b0;
		cfg_index = REG_START;
		cfg_data = 64'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset register values: even, one, collisions and words with small factors.
		words = '{64'd0, 64'd2, 64'd1, 64'd3, 64'd9, 64'd15, 64'd21,
		          64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
		          64'h8000_0000_0000_0001, 64'd3000009};
		send_words(words);
		drain();

		// Start and c of zero hold the walk at zero, so x equals y at once.
		set_regs(64'd0, 64'd0, 32'd1);
		words = '{64'hFFFF_FFFF_FFFF_FFC5, 64'd35, 64'd1};
		send_words(words);
		drain();

		set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
		words = '{rand64() | 64'd1, 64'hFFFF_FFFF_FFFF_FFC5, 64'd77};
		send_words(words);
		drain();

		// A limit of zero ends every odd word other than one with the limit outcome.
		set_regs(64'd5, 64'd3, 32'd0);
		words = '{64'd91, 64'd4};
		send_words(words);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			words = {};
			if (ph == 5) begin
				set_regs(rand64(), rand64(), 32'hFFFF_FFFF);
				repeat (15) words.push_back(small_factor_word());
			end else begin
				set_regs((ph == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64(),
				         (ph == 2) ? 64'd0 : rand64(),
				         $urandom_range(1, 40));
				repeat (18) words.push_back(random_word());
			end
			send_words(words);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hdl/prf_pkg.sv
hdl/prf_ctrl.sv
hdl/prf_dpath.sv
hdl/pollard_rho_factor.sv
tb/sv/pollard_rho_factor_tb.sv
